// ----- rtl/ctrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctrgb_pkg
// Shared types and constants of the chromaticity-to-RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctrgb_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS = 16;
  localparam int CFG_W     = 16;
  localparam int IN_W      = FRAC_BITS + 2;
  localparam int OUT_W     = FRAC_BITS + 1;
  localparam int PZ_W      = FRAC_BITS + 2;
  localparam int COF_W     = 2 * PZ_W + 1;
  localparam int PROD_W    = COF_W + PZ_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int DIV_W     = ACC_W + 1;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int NUM_COEF  = 9;
  localparam int COEF_IDX_W = 4;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_RED_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RED_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_X  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_Y  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_X = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_Y = 3'd7;

  // Reset chromaticities (sRGB primaries, D65 white).
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    16'd41943, 16'd21627, 16'd19661, 16'd39322,
    16'd9830,  16'd3932,  16'd20493, 16'd21561
  };

  localparam logic signed [PZ_W-1:0] ONE_Q   = 18'sd65536;
  localparam logic [OUT_W-1:0]       OUT_ONE = 17'd65536;

  // Matrix derivation sequencer states.
  typedef enum logic [2:0] {
    S_COF,
    S_NUM,
    S_SCALE,
    S_SCALE_WAIT,
    S_COEF,
    S_COEF_WAIT,
    S_IDLE
  } derive_state_e;

  // Status of the derivation unit seen by the datapath.
  typedef struct packed {
    logic busy;
    logic degenerate;
  } derive_status_t;

endpackage : ctrgb_pkg

`default_nettype wire

// ----- rtl/ctrgb_if.sv -----
// ----------------------------------------------------------------------------
// ctrgb_in_if / ctrgb_out_if
// Valid/ready channels carrying color beats into and out of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctrgb_in_if;
  logic                valid;
  logic                ready;
  logic signed [17:0]  comp_x;
  logic signed [17:0]  comp_y;
  logic signed [17:0]  comp_z;

  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface : ctrgb_in_if

interface ctrgb_out_if;
  logic         valid;
  logic         ready;
  logic [16:0]  red_out;
  logic [16:0]  green_out;
  logic [16:0]  blue_out;
  logic         degenerate_setup;

  modport source (output valid, red_out, green_out, blue_out, degenerate_setup,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, degenerate_setup,
                  output ready);
endinterface : ctrgb_out_if

`default_nettype wire

// ----- rtl/ctrgb_div.sv -----
// ----------------------------------------------------------------------------
// ctrgb_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. A new start aborts any division in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrgb_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [ctrgb_pkg::DIV_W-1:0] num_i,
  input  wire logic signed [ctrgb_pkg::DIV_W-1:0] den_i,
  output logic signed [ctrgb_pkg::DIV_W-1:0]      quo_o,
  output logic                                    done_o
);
  import ctrgb_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             run_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [DIV_W:0]   trial;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Magnitudes and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[DIV_W-1] ? DIV_W'(-num_i) : num_i;
      den_q <= den_i[DIV_W-1] ? DIV_W'(-den_i) : den_i;
      neg_q <= num_i[DIV_W-1] ^ den_i[DIV_W-1];
    end else if (run_q) begin
      rem_q <= ge ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign done_o = done_q;

endmodule : ctrgb_div

`default_nettype wire

// ----- rtl/ctrgb_derive.sv -----
// ----------------------------------------------------------------------------
// ctrgb_derive
// Sequencer that derives the 3x3 conversion matrix from the chromaticity
// registers with one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrgb_derive #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          restart_i,
  input  wire logic [ctrgb_pkg::CFG_W-1:0]   cfg_i [ctrgb_pkg::NUM_REGS],
  output logic signed [COEF_WIDTH-1:0]       coef_o [ctrgb_pkg::NUM_COEF],
  output ctrgb_pkg::derive_status_t          status_o
);
  import ctrgb_pkg::*;

  localparam logic signed [DIV_W-1:0] CMAX =
    DIV_W'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
  localparam logic signed [DIV_W-1:0] CMIN = -CMAX - DIV_W'(1);

  derive_state_e state_q, state_d;
  logic [1:0] i_q, i_d, j_q, j_d, s_q, s_d;

  logic signed [PZ_W-1:0]   px [3], py [3], pz [3], pv [3], qv [3], wv [3];
  logic [1:0]               a_idx, b_idx;
  logic [COEF_IDX_W-1:0]    row_base, k_col, k_num;
  logic signed [COF_W-1:0]  mul_a;
  logic signed [PZ_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [COF_W-1:0]      cof_q  [NUM_COEF];
  logic signed [COEF_WIDTH-1:0] coef_q [NUM_COEF];
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [DIV_W-1:0]      scale_q;
  logic                         row_zero_q, flag_q;

  logic                   div_start, div_done, col_adv;
  logic signed [DIV_W-1:0] div_num, div_den, div_quo;

  // Primaries with implied z, and the white point.
  always_comb begin
    px[0] = PZ_W'(cfg_i[REG_RED_X]);
    py[0] = PZ_W'(cfg_i[REG_RED_Y]);
    px[1] = PZ_W'(cfg_i[REG_GREEN_X]);
    py[1] = PZ_W'(cfg_i[REG_GREEN_Y]);
    px[2] = PZ_W'(cfg_i[REG_BLUE_X]);
    py[2] = PZ_W'(cfg_i[REG_BLUE_Y]);
    for (int n = 0; n < 3; n++) begin
      pz[n] = ONE_Q - (px[n] + py[n]);
    end
    wv[0] = PZ_W'(cfg_i[REG_WHITE_X]);
    wv[1] = PZ_W'(cfg_i[REG_WHITE_Y]);
    wv[2] = ONE_Q - (wv[0] + wv[1]);
  end

  // Cofactor column j is P[a]*Q[b] - P[b]*Q[a] for a column-specific pair.
  always_comb begin
    case (j_q)
      2'd0:    begin pv = py; qv = pz; end
      2'd1:    begin pv = pz; qv = px; end
      default: begin pv = px; qv = py; end
    endcase
    case (i_q)
      2'd0:    begin a_idx = 2'd1; b_idx = 2'd2; row_base = 4'd0; end
      2'd1:    begin a_idx = 2'd2; b_idx = 2'd0; row_base = 4'd3; end
      default: begin a_idx = 2'd0; b_idx = 2'd1; row_base = 4'd6; end
    endcase
    k_col = row_base + COEF_IDX_W'(j_q);
    k_num = row_base + COEF_IDX_W'(s_q);
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_COF) begin
      mul_a = COF_W'(s_q[0] ? pv[b_idx] : pv[a_idx]);
      mul_b = s_q[0] ? qv[a_idx] : qv[b_idx];
    end else if (state_q == S_NUM) begin
      mul_a = cof_q[k_num];
      mul_b = wv[s_q];
    end
  end

  assign prod = mul_a * mul_b;

  // Next state and divider requests.
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    s_d       = s_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    col_adv   = 1'b0;
    unique case (state_q)
      S_COF: begin
        if (!s_q[0]) begin
          s_d = 2'd1;
        end else begin
          s_d = 2'd0;
          if (j_q == 2'd2) begin
            j_d = 2'd0;
            if (i_q == 2'd2) begin
              i_d     = 2'd0;
              state_d = S_NUM;
            end else begin
              i_d = i_q + 2'd1;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end
      end
      S_NUM: begin
        if (s_q == 2'd2) begin
          s_d     = 2'd0;
          state_d = S_SCALE;
        end else begin
          s_d = s_q + 2'd1;
        end
      end
      S_SCALE: begin
        j_d = 2'd0;
        if (wv[1] == '0) begin
          state_d = S_COEF;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(acc_q);
          div_den   = DIV_W'(wv[1]);
          state_d   = S_SCALE_WAIT;
        end
      end
      S_SCALE_WAIT: begin
        if (div_done) begin
          state_d = S_COEF;
        end
      end
      S_COEF: begin
        if (row_zero_q) begin
          col_adv = 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(cof_q[k_col]) <<< FRAC_BITS;
          div_den   = scale_q;
          state_d   = S_COEF_WAIT;
        end
      end
      S_COEF_WAIT: begin
        col_adv = div_done;
      end
      S_IDLE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Step to the next coefficient, the next row, or finish.
    if (col_adv) begin
      if (j_q == 2'd2) begin
        j_d = 2'd0;
        if (i_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + 2'd1;
          s_d     = 2'd0;
          state_d = S_NUM;
        end
      end else begin
        j_d     = j_q + 2'd1;
        state_d = S_COEF;
      end
    end

    // A register write starts the derivation over.
    if (restart_i) begin
      state_d = S_COF;
      i_d     = 2'd0;
      j_d     = 2'd0;
      s_d     = 2'd0;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COF;
      i_q     <= 2'd0;
      j_q     <= 2'd0;
      s_q     <= 2'd0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      s_q     <= s_d;
      if (restart_i) begin
        flag_q <= 1'b0;
      end else if (state_q == S_SCALE && wv[1] == '0) begin
        flag_q <= 1'b1;
      end else if (state_q == S_SCALE_WAIT && div_done && div_quo == '0) begin
        flag_q <= 1'b1;
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_COF: begin
        if (!s_q[0]) begin
          acc_q <= ACC_W'(prod);
        end else begin
          cof_q[k_col] <= COF_W'(acc_q - ACC_W'(prod));
        end
      end
      S_NUM: begin
        acc_q <= ((s_q == 2'd0) ? '0 : acc_q) + ACC_W'(prod);
      end
      S_SCALE: begin
        row_zero_q <= (wv[1] == '0);
      end
      S_SCALE_WAIT: begin
        if (div_done) begin
          scale_q    <= div_quo;
          row_zero_q <= (div_quo == '0);
        end
      end
      S_COEF: begin
        if (row_zero_q) begin
          if (cof_q[k_col] > 0) begin
            coef_q[k_col] <= CMAX[COEF_WIDTH-1:0];
          end else if (cof_q[k_col] < 0) begin
            coef_q[k_col] <= CMIN[COEF_WIDTH-1:0];
          end else begin
            coef_q[k_col] <= '0;
          end
        end
      end
      S_COEF_WAIT: begin
        if (div_done) begin
          if (div_quo > CMAX) begin
            coef_q[k_col] <= CMAX[COEF_WIDTH-1:0];
          end else if (div_quo < CMIN) begin
            coef_q[k_col] <= CMIN[COEF_WIDTH-1:0];
          end else begin
            coef_q[k_col] <= div_quo[COEF_WIDTH-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  ctrgb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  assign coef_o              = coef_q;
  assign status_o.busy       = (state_q != S_IDLE);
  assign status_o.degenerate = flag_q;

endmodule : ctrgb_derive

`default_nettype wire

// ----- rtl/ctrgb_pipe.sv -----
// ----------------------------------------------------------------------------
// ctrgb_pipe
// Four-stage matrix multiply, sum and clip pipeline for color beats.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrgb_pipe #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic signed [COEF_WIDTH-1:0] coef_i [ctrgb_pkg::NUM_COEF],
  input  wire ctrgb_pkg::derive_status_t    status_i,
  ctrgb_in_if.sink                          in_i,
  ctrgb_out_if.source                       out_o
);
  import ctrgb_pkg::*;

  localparam int PW = COEF_WIDTH + IN_W;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SW-1:0] ONE  = SW'(64'sd1 <<< FRAC_BITS);

  logic                   adv;
  logic [3:0]             v_q;
  logic signed [IN_W-1:0] in_q   [3];
  logic signed [PW-1:0]   prod_q [NUM_COEF];
  logic signed [SW-1:0]   sum_q  [3];
  logic [OUT_W-1:0]       rgb_q  [3];
  logic                   degen_q;
  logic signed [SW-1:0]   rnd    [3];

  // The whole pipeline moves unless a finished beat waits at the output.
  assign adv         = !v_q[3] || out_o.ready;
  assign in_i.ready  = adv && !status_i.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], in_i.valid && in_i.ready};
    end
  end

  // Rounded rows before the clip.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = (sum_q[r] + HALF) >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Stage 1: capture the components.
      in_q[0] <= in_i.comp_x;
      in_q[1] <= in_i.comp_y;
      in_q[2] <= in_i.comp_z;
      // Stage 2: nine coefficient products.
      for (int k = 0; k < NUM_COEF; k++) begin
        prod_q[k] <= PW'(coef_i[k]) * PW'(in_q[k % 3]);
      end
      // Stage 3: row sums.
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= SW'(prod_q[3*r]) + SW'(prod_q[3*r+1]) + SW'(prod_q[3*r+2]);
      end
      // Stage 4: round half up and clip to [0, 1].
      for (int r = 0; r < 3; r++) begin
        if (sum_q[r] <= 0) begin
          rgb_q[r] <= '0;
        end else if (rnd[r] > ONE) begin
          rgb_q[r] <= OUT_ONE;
        end else begin
          rgb_q[r] <= rnd[r][OUT_W-1:0];
        end
      end
      degen_q <= status_i.degenerate;
    end
  end

  assign out_o.valid            = v_q[3];
  assign out_o.red_out          = rgb_q[0];
  assign out_o.green_out        = rgb_q[1];
  assign out_o.blue_out         = rgb_q[2];
  assign out_o.degenerate_setup = degen_q;

endmodule : ctrgb_pipe

`default_nettype wire

// ----- rtl/chromaticity_to_rgb_convert_top.sv -----
// Each accepted input beat passes the input, product, row-sum and clip
// registers to its output beat. Throughput: one beat per cycle through the
// four-stage multiply/sum/clip pipe while the output is ready and no
// derivation runs. After reset and every register write a sequencer with one
// multiplier and a one-bit-per-cycle divider rederives the matrix, accepting
// no input. Reset loads the sRGB primaries and D65 white point.
// ----------------------------------------------------------------------------
// chromaticity_to_rgb_convert_top
// Converts XYZ color beats to clipped RGB with a matrix derived from the
// configured primaries and white point.
// ----------------------------------------------------------------------------
`default_nettype none

module chromaticity_to_rgb_convert_top #(
  parameter int COEF_WIDTH = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ctrgb_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ctrgb_pkg::CFG_W-1:0]       cfg_wdata_i,
  ctrgb_in_if.sink                               in_i,
  ctrgb_out_if.source                            out_o
);
  import ctrgb_pkg::*;

  logic [CFG_W-1:0]             cfg_q [NUM_REGS];
  logic signed [COEF_WIDTH-1:0] coef  [NUM_COEF];
  derive_status_t               status;

  // Chromaticity registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  ctrgb_derive #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_derive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .cfg_i     (cfg_q),
    .coef_o    (coef),
    .status_o  (status)
  );

  ctrgb_pipe #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coef_i   (coef),
    .status_i (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule : chromaticity_to_rgb_convert_top

`default_nettype wire
